### hw/rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the sphere pixel shader
// fixed point format, shading constants and the widths of the pipeline units
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  // fixed point: FB fraction bits, one = 2**FB
  localparam int FB        = 16;
  localparam int ONE_W     = FB + 1;       // holds 0..one
  localparam int NUM_W     = 2 * FB + 1;   // dividend and radicand width
  localparam int DIV_STAGES  = NUM_W;      // one quotient bit per stage
  localparam int SQRT_STAGES = ONE_W;      // one root bit per stage

  // normal component magnitude bound: centre offsets give dist >= 512
  localparam int MAG_W = 2 * FB - 8;
  localparam int DOT_W = MAG_W + FB + 3;   // signed dot product sum
  localparam int NDL_W = DOT_W - FB;       // dot product after the shift
  localparam int DIF_W = NDL_W + 1;        // diffuse term
  localparam int VAL_W = DIF_W + 2;        // shade before clamping

  localparam int RAD_W      = 7;
  localparam int MAX_RADIUS = 127;
  localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(50);

  localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FB;

  // constants held with 30 fraction bits, truncated to FB
  localparam logic [FB-1:0] LIGHT_XY  = FB'(64'd552435610 >> (30 - FB));
  localparam logic [FB-1:0] LIGHT_Z   = FB'(64'd736580814 >> (30 - FB));
  localparam logic [FB-1:0] HALF_XY   = FB'(64'd300841951 >> (30 - FB));
  localparam logic [FB-1:0] HALF_Z    = FB'(64'd985854831 >> (30 - FB));
  localparam logic [FB-1:0] AMBIENT   = FB'(64'd193273528 >> (30 - FB));
  localparam logic [FB-1:0] SPEC_GAIN = FB'(64'd751619276 >> (30 - FB));
  localparam logic [FB-1:0] EDGE_GAIN = FB'(64'd322122547 >> (30 - FB));
  localparam logic [FB-1:0] AMB_COMP  = FB'((64'd1 << FB) - (64'd193273528 >> (30 - FB)));
  localparam logic [ONE_W-1:0] DIST_EPS = ONE_W'((64'd1 << FB) / 1000);

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic       inside_disc;
  } shade_t;

endpackage

`default_nettype wire

### hw/rtl/sphere_pixel_shader.sv
// ----------------------------------------------------------------------------
// sphere_pixel_shader: per-pixel blinn-phong shading of a sphere
// throughput: one pixel per cycle, busy is only high during reset
// the two 33-stage dividers and the 17-stage square root lie in series
// reset clears all valid bits and loads radius 50; results cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_pixel_shader (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sps_pkg::pixel_t           pixel,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sps_pkg::RAD_W-1:0] cfg_data,
  output logic                      done,
  output sps_pkg::shade_t           result
);
  import sps_pkg::*;

  // registers from the start transfer to the done strobe
  localparam int PIPE_REGS = 2 * DIV_STAGES + SQRT_STAGES + 14;

  typedef struct packed {
    logic in_disc;
    logic sx;
    logic sy;
  } side_a_t;

  typedef struct packed {
    logic             in_disc;
    logic             sx;
    logic             sy;
    logic [ONE_W-1:0] dsq;
    logic [ONE_W-1:0] dxq;
    logic [ONE_W-1:0] dyq;
  } side_b_t;

  typedef struct packed {
    logic             in_disc;
    logic             sx;
    logic             sy;
    logic             near_zero;
    logic [ONE_W-1:0] dsq;
    logic [ONE_W-1:0] nz;
  } side_c_t;

  typedef struct packed {
    logic             in_disc;
    logic [ONE_W-1:0] atten;
    logic [DIF_W-1:0] diff;
  } tail_t;

  // ---------------------------------------------------------------- config
  logic [RAD_W-1:0] radius;
  logic [RAD_W-1:0] r_eff;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  // radius zero acts as radius one
  assign r_eff = (radius == '0) ? RAD_W'(1) : radius;

  // ---------------------------------------------------------------- stage 1
  // signed offsets from the centre at (r+1, r+1)
  logic             v1;
  logic [9:0]       dxi1, dyi1;
  logic [RAD_W-1:0] r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dxi1 <= 10'(pixel.pixel_x) - 10'(r_eff) - 10'd1;
    dyi1 <= 10'(pixel.pixel_y) - 10'(r_eff) - 10'd1;
    r1   <= r_eff;
  end

  // ---------------------------------------------------------------- stage 2
  // squared distance and squared radius
  logic             v2;
  logic [7:0]       adx2, ady2;
  logic             sx2, sy2;
  logic [16:0]      sq2;
  logic [13:0]      r2_2;
  logic [RAD_W-1:0] rad2;
  logic [7:0]       adx_c, ady_c;

  assign adx_c = dxi1[9] ? 8'(-dxi1) : dxi1[7:0];
  assign ady_c = dyi1[9] ? 8'(-dyi1) : dyi1[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    adx2 <= adx_c;
    ady2 <= ady_c;
    sx2  <= dxi1[9];
    sy2  <= dyi1[9];
    sq2  <= 17'(adx_c * adx_c) + 17'(ady_c * ady_c);
    r2_2 <= r1 * r1;
    rad2 <= r1;
  end

  // ---------------------------------------------------------------- dividers a
  // d^2 = sq/r^2 and the per-axis offsets dx/r, dy/r
  logic [NUM_W-1:0] dsq_quo, dxq_quo, dyq_quo;
  side_a_t          sa [DIV_STAGES];
  logic [DIV_STAGES-1:0] va;

  sps_div u_div_dsq (
    .clk      (clk),
    .dividend (NUM_W'({sq2[13:0], {FB{1'b0}}})),
    .divisor  (ONE_W'(r2_2)),
    .quotient (dsq_quo)
  );

  sps_div u_div_dx (
    .clk      (clk),
    .dividend (NUM_W'({adx2, {FB{1'b0}}})),
    .divisor  (ONE_W'(rad2)),
    .quotient (dxq_quo)
  );

  sps_div u_div_dy (
    .clk      (clk),
    .dividend (NUM_W'({ady2, {FB{1'b0}}})),
    .divisor  (ONE_W'(rad2)),
    .quotient (dyq_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
    end else begin
      va <= {va[DIV_STAGES-2:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    sa[0] <= '{in_disc: (sq2 <= 17'(r2_2)), sx: sx2, sy: sy2};
    for (int i = 1; i < DIV_STAGES; i++) begin
      sa[i] <= sa[i-1];
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic             v4;
  side_a_t          s4;
  logic [ONE_W-1:0] dsq4, dxq4, dyq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= va[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    s4   <= sa[DIV_STAGES-1];
    dsq4 <= (dsq_quo > NUM_W'(ONE)) ? ONE : dsq_quo[ONE_W-1:0];
    dxq4 <= dxq_quo[ONE_W-1:0];
    dyq4 <= dyq_quo[ONE_W-1:0];
  end

  // ---------------------------------------------------------------- square roots
  // distance sqrt(d^2) and normal z sqrt(1 - d^2)
  logic [ONE_W-1:0] dist_root, nz_root;
  side_b_t          sb [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] vb;

  sps_sqrt u_sqrt_dist (
    .clk      (clk),
    .radicand ({dsq4, {FB{1'b0}}}),
    .root     (dist_root)
  );

  sps_sqrt u_sqrt_nz (
    .clk      (clk),
    .radicand ({ONE_W'(ONE - dsq4), {FB{1'b0}}}),
    .root     (nz_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else begin
      vb <= {vb[SQRT_STAGES-2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    sb[0] <= '{in_disc: s4.in_disc, sx: s4.sx, sy: s4.sy,
               dsq: dsq4, dxq: dxq4, dyq: dyq4};
    for (int i = 1; i < SQRT_STAGES; i++) begin
      sb[i] <= sb[i-1];
    end
  end

  // ---------------------------------------------------------------- dividers b
  // unit in-plane direction: offset over distance
  side_b_t          sbt;
  logic [NUM_W-1:0] mx_quo, my_quo;
  side_c_t          sc [DIV_STAGES];
  logic [DIV_STAGES-1:0] vc;

  assign sbt = sb[SQRT_STAGES-1];

  sps_div u_div_mx (
    .clk      (clk),
    .dividend ({sbt.dxq, {FB{1'b0}}}),
    .divisor  (dist_root),
    .quotient (mx_quo)
  );

  sps_div u_div_my (
    .clk      (clk),
    .dividend ({sbt.dyq, {FB{1'b0}}}),
    .divisor  (dist_root),
    .quotient (my_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= '0;
    end else begin
      vc <= {vc[DIV_STAGES-2:0], vb[SQRT_STAGES-1]};
    end
  end

  always_ff @(posedge clk) begin
    // centre pixel: direction forced to zero at or below the distance threshold
    sc[0] <= '{in_disc: sbt.in_disc, sx: sbt.sx, sy: sbt.sy,
               near_zero: (dist_root <= DIST_EPS), dsq: sbt.dsq, nz: nz_root};
    for (int i = 1; i < DIV_STAGES; i++) begin
      sc[i] <= sc[i-1];
    end
  end

  // ---------------------------------------------------------------- stage 5
  side_c_t          sct;
  logic             v5;
  logic             in5, sx5, sy5;
  logic [MAG_W-1:0] mx5, my5;
  logic [ONE_W-1:0] nz5, dsq5;

  assign sct = sc[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= vc[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    in5  <= sct.in_disc;
    sx5  <= sct.sx;
    sy5  <= sct.sy;
    mx5  <= sct.near_zero ? '0 : mx_quo[MAG_W-1:0];
    my5  <= sct.near_zero ? '0 : my_quo[MAG_W-1:0];
    nz5  <= sct.nz;
    dsq5 <= sct.dsq;
  end

  // ---------------------------------------------------------------- stage 6
  // component products of the light and half vector dot products
  logic                  v6, in6, sx6, sy6;
  logic [MAG_W+FB-1:0]   plx6, ply6, phx6, phy6;
  logic [ONE_W+FB-1:0]   plz6, phz6, eprod6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    in6    <= in5;
    sx6    <= sx5;
    sy6    <= sy5;
    plx6   <= mx5 * LIGHT_XY;
    ply6   <= my5 * LIGHT_XY;
    plz6   <= nz5 * LIGHT_Z;
    phx6   <= mx5 * HALF_XY;
    phy6   <= my5 * HALF_XY;
    phz6   <= nz5 * HALF_Z;
    eprod6 <= dsq5 * EDGE_GAIN;
  end

  // ---------------------------------------------------------------- stage 7
  // light and half have negative x, y: a negative normal axis adds
  logic signed [DOT_W-1:0] tlx, tly, thx, thy, raw_l, raw_h;
  logic [NDL_W-1:0]        ndl_c, ndh_full;
  logic [ONE_W-1:0]        ndh_c;

  always_comb begin
    tlx   = sx6 ? $signed(DOT_W'(plx6)) : -$signed(DOT_W'(plx6));
    tly   = sy6 ? $signed(DOT_W'(ply6)) : -$signed(DOT_W'(ply6));
    thx   = sx6 ? $signed(DOT_W'(phx6)) : -$signed(DOT_W'(phx6));
    thy   = sy6 ? $signed(DOT_W'(phy6)) : -$signed(DOT_W'(phy6));
    raw_l = tlx + tly + $signed(DOT_W'(plz6));
    raw_h = thx + thy + $signed(DOT_W'(phz6));
    ndl_c    = (raw_l > 0) ? NDL_W'(raw_l >>> FB) : '0;
    ndh_full = (raw_h > 0) ? NDL_W'(raw_h >>> FB) : '0;
    ndh_c    = (ndh_full > NDL_W'(ONE)) ? ONE : ndh_full[ONE_W-1:0];
  end

  logic             v7, in7;
  logic [NDL_W-1:0] ndl7;
  logic [ONE_W-1:0] ndh7, atten7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    in7    <= in6;
    ndl7   <= ndl_c;
    ndh7   <= ndh_c;
    atten7 <= ONE - ONE_W'(eprod6 >> FB);
  end

  // ---------------------------------------------------------------- stages 8 to 12
  // diffuse term, and (n.h)^32 by five squarings
  logic [FB+NDL_W-1:0] dprod8;
  logic [2*ONE_W-1:0]  ndh_sq;
  logic [2*ONE_W-1:0]  pw_sq [0:3];
  logic [ONE_W-1:0]    pw [0:4];
  logic                v8, in8;
  logic [ONE_W-1:0]    atten8;
  tail_t               tl [0:3];
  logic [3:0]          vt;

  always_comb begin
    ndh_sq = ndh7 * ndh7;
    for (int k = 0; k < 4; k++) begin
      pw_sq[k] = pw[k] * pw[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      vt <= '0;
    end else begin
      v8 <= v7;
      vt <= {vt[2:0], v8};
    end
  end

  always_ff @(posedge clk) begin
    in8    <= in7;
    atten8 <= atten7;
    dprod8 <= AMB_COMP * ndl7;
    pw[0]  <= ONE_W'(ndh_sq >> FB);
    tl[0]  <= '{in_disc: in8, atten: atten8,
                diff: DIF_W'(AMBIENT) + DIF_W'(dprod8 >> FB)};
    for (int k = 1; k < 4; k++) begin
      tl[k] <= tl[k-1];
    end
    for (int k = 1; k < 5; k++) begin
      pw[k] <= ONE_W'(pw_sq[k-1] >> FB);
    end
  end

  // ---------------------------------------------------------------- stage 13
  logic [FB+ONE_W-1:0]    sprod;
  logic [DIF_W+ONE_W-1:0] dmul_c;
  logic                   v13, in13;
  logic [FB-1:0]          spec13;
  logic [DIF_W+ONE_W-1:0] dmul13;

  always_comb begin
    sprod  = pw[4] * SPEC_GAIN;
    dmul_c = tl[3].diff * tl[3].atten;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else begin
      v13 <= vt[3];
    end
  end

  always_ff @(posedge clk) begin
    in13   <= tl[3].in_disc;
    spec13 <= FB'(sprod >> FB);
    dmul13 <= dmul_c;
  end

  // ---------------------------------------------------------------- stage 14
  logic [VAL_W-1:0] val_c;
  logic             v14, in14;
  logic [ONE_W-1:0] val14;

  assign val_c = VAL_W'(dmul13 >> FB) + VAL_W'(spec13);

  always_ff @(posedge clk) begin
    if (rst) begin
      v14 <= 1'b0;
    end else begin
      v14 <= v13;
    end
  end

  always_ff @(posedge clk) begin
    in14  <= in13;
    val14 <= (val_c > VAL_W'(ONE)) ? ONE : val_c[ONE_W-1:0];
  end

  // ---------------------------------------------------------------- output
  logic [ONE_W+7:0] bprod;
  logic [8:0]       bright_full;
  logic [7:0]       bright;

  always_comb begin
    bprod       = val14 * 8'd255;
    bright_full = 9'(bprod >> FB);
    bright      = (bright_full > 9'd255) ? 8'd255 : bright_full[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v14;
    end
  end

  // outside the disc the result is zero
  always_ff @(posedge clk) begin
    result.brightness  <= in14 ? bright : 8'd0;
    result.inside_disc <= in14;
  end

  // ---------------------------------------------------------------- checks
  // every strobe traces back to a start transfer that ran through the whole pipeline
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_REGS))
    else $error("done without a matching start transfer");

  // pixels outside the disc are black
  a_outside_black: assert property (@(posedge clk) disable iff (rst)
    (done && !result.inside_disc) |-> (result.brightness == 8'd0))
    else $error("nonzero brightness outside the disc");

  // a nonzero shade only appears inside the disc
  a_full_inside: assert property (@(posedge clk) disable iff (rst)
    (done && result.brightness != 8'd0) |-> result.inside_disc)
    else $error("lit pixel flagged outside the disc");

endmodule

`default_nettype wire

### hw/rtl/sps_div.sv
// ----------------------------------------------------------------------------
// sps_div: pipelined restoring divider
// one quotient bit per register stage, a new division enters every cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sps_div (
  input  logic                       clk,
  input  logic [sps_pkg::NUM_W-1:0]  dividend,
  input  logic [sps_pkg::ONE_W-1:0]  divisor,
  output logic [sps_pkg::NUM_W-1:0]  quotient
);
  import sps_pkg::*;

  logic [ONE_W-1:0] rem_s [0:DIV_STAGES];
  logic [NUM_W-1:0] num_s [0:DIV_STAGES];
  logic [NUM_W-1:0] quo_s [0:DIV_STAGES];
  logic [ONE_W-1:0] den_s [0:DIV_STAGES];

  assign rem_s[0] = '0;
  assign num_s[0] = dividend;
  assign quo_s[0] = '0;
  assign den_s[0] = divisor;

  genvar g;
  for (g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [ONE_W:0] trial;
    logic           fits;

    // bring down the next dividend bit
    assign trial = {rem_s[g], num_s[g][NUM_W-1]};
    assign fits  = trial >= {1'b0, den_s[g]};

    always_ff @(posedge clk) begin
      rem_s[g+1] <= fits ? ONE_W'(trial - {1'b0, den_s[g]}) : trial[ONE_W-1:0];
      num_s[g+1] <= num_s[g] << 1;
      quo_s[g+1] <= {quo_s[g][NUM_W-2:0], fits};
      den_s[g+1] <= den_s[g];
    end
  end

  assign quotient = quo_s[DIV_STAGES];

endmodule

`default_nettype wire

### hw/rtl/sps_sqrt.sv
// ----------------------------------------------------------------------------
// sps_sqrt: pipelined integer square root
// digit by digit, one root bit per register stage, floor of the exact root
// ----------------------------------------------------------------------------
`default_nettype none

module sps_sqrt (
  input  logic                       clk,
  input  logic [sps_pkg::NUM_W-1:0]  radicand,
  output logic [sps_pkg::ONE_W-1:0]  root
);
  import sps_pkg::*;

  logic [NUM_W-1:0] rem_s [0:SQRT_STAGES];
  logic [ONE_W-1:0] res_s [0:SQRT_STAGES];

  assign rem_s[0] = radicand;
  assign res_s[0] = '0;

  genvar g;
  for (g = 0; g < SQRT_STAGES; g++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - g;
    logic [NUM_W:0] trial;
    logic           fits;

    // (res + 2^b)^2 - res^2, res only has bits above b
    assign trial = ((NUM_W+1)'(res_s[g]) << (B + 1)) | ((NUM_W+1)'(1) << (2 * B));
    assign fits  = {1'b0, rem_s[g]} >= trial;

    always_ff @(posedge clk) begin
      rem_s[g+1] <= fits ? NUM_W'({1'b0, rem_s[g]} - trial) : rem_s[g];
      res_s[g+1] <= fits ? (res_s[g] | (ONE_W'(1) << B)) : res_s[g];
    end
  end

  assign root = res_s[SQRT_STAGES];

endmodule

`default_nettype wire

### sim/sps_checker.sv
// ----------------------------------------------------------------------------
// sps_checker: shade predictor and result scoreboard
// watches pixel, config and result transfers, predicts each pixel's shade
// in truncating fixed point and compares results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sps_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  sps_pkg::pixel_t           pixel,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [sps_pkg::RAD_W-1:0] cfg_data,
  input  logic                      done,
  input  sps_pkg::shade_t           result,
  output int                        errors,
  output int                        pending
);

  localparam int F = 16;
  localparam longint K_ONE  = 64'd1 << F;
  localparam longint K_LXY  = 64'd552435610 >> (30 - F);
  localparam longint K_LZ   = 64'd736580814 >> (30 - F);
  localparam longint K_HXY  = 64'd300841951 >> (30 - F);
  localparam longint K_HZ   = 64'd985854831 >> (30 - F);
  localparam longint K_AMB  = 64'd193273528 >> (30 - F);
  localparam longint K_SPEC = 64'd751619276 >> (30 - F);
  localparam longint K_EDGE = 64'd322122547 >> (30 - F);
  localparam longint K_EPS  = K_ONE / 1000;

  logic [sps_pkg::RAD_W-1:0] radius_q;
  sps_pkg::shade_t           shade_fifo[$];

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint unsigned p;
    p = longint'(a) * longint'(b);
    return longint'(p >> F);
  endfunction

  function automatic sps_pkg::shade_t shade_of(logic [7:0] px, logic [7:0] py,
                                               logic [sps_pkg::RAD_W-1:0] rad);
    longint r, dx, dy, sq, r2, dsq, dlen, nx, ny, nz, mx, my;
    longint ndl_raw, ndl, dif, ndh_raw, ndh, pw, spec, edge_f, val, br;
    sps_pkg::shade_t s;
    r = (rad == 0) ? 1 : rad;
    dx = longint'(px) - (r + 1);
    dy = longint'(py) - (r + 1);
    sq = dx * dx + dy * dy;
    r2 = r * r;
    s = '0;
    if (sq > r2) return s;
    dsq = (sq << F) / r2;
    if (dsq > K_ONE) dsq = K_ONE;
    dlen = int_sqrt(dsq << F);
    nx = 0;
    ny = 0;
    // tiny distance near the centre: flat in-plane normal
    if (dlen > K_EPS) begin
      mx = ((((dx < 0 ? -dx : dx) << F) / r) << F) / dlen;
      my = ((((dy < 0 ? -dy : dy) << F) / r) << F) / dlen;
      nx = (dx < 0) ? -mx : mx;
      ny = (dy < 0) ? -my : my;
    end
    nz = int_sqrt((K_ONE - dsq) << F);
    ndl_raw = -nx * K_LXY - ny * K_LXY + nz * K_LZ;
    ndl = (ndl_raw > 0) ? (ndl_raw >> F) : 0;
    dif = K_AMB + fmul(K_ONE - K_AMB, ndl);
    ndh_raw = -nx * K_HXY - ny * K_HXY + nz * K_HZ;
    ndh = (ndh_raw > 0) ? (ndh_raw >> F) : 0;
    if (ndh > K_ONE) ndh = K_ONE;
    pw = ndh;
    for (int i = 0; i < 5; i++) pw = fmul(pw, pw);
    spec = fmul(pw, K_SPEC);
    edge_f = K_ONE - fmul(dsq, K_EDGE);
    if (edge_f < 0) edge_f = 0;
    val = fmul(dif, edge_f) + spec;
    if (val > K_ONE) val = K_ONE;
    br = fmul(val, 255);
    if (br > 255) br = 255;
    s.brightness  = br[7:0];
    s.inside_disc = 1'b1;
    return s;
  endfunction

  assign pending = shade_fifo.size();

  always @(posedge clk) begin
    sps_pkg::shade_t exp_s;
    int              bad;
    bad = 0;
    if (rst) begin
      radius_q <= sps_pkg::RAD_W'(50);
      shade_fifo.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) radius_q <= cfg_data;
      if (start && !busy) shade_fifo.push_back(shade_of(pixel.pixel_x, pixel.pixel_y, radius_q));
      if (done) begin
        if (shade_fifo.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
          bad++;
        end else begin
          exp_s = shade_fifo.pop_front();
          if (result.brightness !== exp_s.brightness) begin
            $display("%0t: brightness expected %0d actual %0d", $time,
                     exp_s.brightness, result.brightness);
            bad++;
          end
          if (result.inside_disc !== exp_s.inside_disc) begin
            $display("%0t: inside_disc expected %0d actual %0d", $time,
                     exp_s.inside_disc, result.inside_disc);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

### sim/tb_sphere_pixel_shader.sv
// ----------------------------------------------------------------------------
// tb_sphere_pixel_shader: stimulus and verdict for the sphere pixel shader
// directed pixels at disc edges and centre, then random bursts over several
// radii including zero and the maximum; a separate checker scores results
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sphere_pixel_shader;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  sps_pkg::pixel_t           pixel;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [sps_pkg::RAD_W-1:0] cfg_data;
  logic                      done;
  sps_pkg::shade_t           result;
  int                        errors;
  int                        pending;

  // radius currently programmed, used to aim pixels into the square
  int                        cur_rad;
  // burst bookkeeping for the sender
  int                        burst_left;

  sphere_pixel_shader dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  sps_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .result(result), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous stop: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // one pixel transfer; start stays high so bursts run back to back
  task automatic send_pixel(input int px, input int py);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
      // some bursts run to 200 pixels
      if ($urandom_range(0, 3) == 0) burst_left = 200;
    end
    start <= 1'b1;
    pixel <= '{pixel_x: 8'(px), pixel_y: 8'(py)};
    do @(posedge clk); while (busy);
    burst_left--;
  endtask

  // drain the pipeline, let it settle, then write the radius register
  task automatic set_radius(input int v);
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (110) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= sps_pkg::RAD_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_rad = (v == 0) ? 1 : v;
  endtask

  task automatic random_phase(input int n);
    int side, c;
    for (int i = 0; i < n; i++) begin
      side = 2 * cur_rad + 2;
      c = cur_rad + 1;
      case ($urandom_range(0, 9))
        0, 1:    send_pixel($urandom_range(0, 255), $urandom_range(0, 255));
        2:       send_pixel(c + $urandom_range(0, 2) - 1, c + $urandom_range(0, 2) - 1);
        default: send_pixel($urandom_range(0, side), $urandom_range(0, side));
      endcase
    end
  endtask

  initial begin
    int c;
    logic [sps_pkg::RAD_W-1:0] radii[8];
    rst = 1'b1;
    start = 1'b0;
    pixel = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    burst_left = 0;
    cur_rad = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed at reset radius: centre, axis edges, corners, field extremes
    c = 51;
    send_pixel(c, c);
    send_pixel(c + 1, c);
    send_pixel(c - 50, c);
    send_pixel(c + 50, c);
    send_pixel(c, c - 50);
    send_pixel(c, c + 50);
    send_pixel(c + 51, c);
    send_pixel(c + 35, c + 35);
    send_pixel(c - 35, c - 35);
    send_pixel(0, 0);
    send_pixel(255, 255);
    send_pixel(0, 255);
    send_pixel(255, 0);
    send_pixel(102, 102);

    // radius zero acts as one
    set_radius(0);
    send_pixel(2, 2);
    send_pixel(1, 2);
    send_pixel(3, 2);
    send_pixel(1, 1);
    // largest radius
    set_radius(127);
    send_pixel(128, 128);
    send_pixel(1, 128);
    send_pixel(255, 128);
    send_pixel(128, 255);
    send_pixel(0, 0);

    radii = '{7'd127, 7'd1, 7'd0, 7'd50, 7'd3, 7'd90, 7'd17, 7'd64};
    foreach (radii[k]) begin
      set_radius(k < 5 ? int'(radii[k]) : int'($urandom_range(1, 127)));
      random_phase(150);
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (120) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/sps_pkg.sv
hw/rtl/sps_div.sv
hw/rtl/sps_sqrt.sv
hw/rtl/sphere_pixel_shader.sv
sim/sps_checker.sv
sim/tb_sphere_pixel_shader.sv
